/* rtl/rrts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared widths, request and status codes, controller states and the
// control word that the controller broadcasts to the row of task cells.
// ---------------------------------------------------------------------------
package rrts_pkg;

	localparam int unsigned SLOT_W = 6;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_REG   = 2'd1,
		REQ_DELAY = 2'd2,
		REQ_SCHED = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_IDLE_DLY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              tick_go;
		logic              inject;
		logic [SLOT_W-1:0] start;
		logic              flush;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
		logic [DATA_W-1:0] wr_value;
		logic              wr_ready;
	} rrts_ctl_t;

endpackage
`default_nettype wire

/* rtl/rrts_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one request word.
// ---------------------------------------------------------------------------
interface rrts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] delay_ticks;

	modport source (output valid, req_type, delay_ticks, input ready);
	modport sink (input valid, req_type, delay_ticks, output ready);
endinterface
`default_nettype wire

/* rtl/rrts_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
interface rrts_res_if;
	logic        valid;
	logic        ready;
	logic [5:0]  chosen_task;
	logic        switch_needed;
	logic [31:0] ready_bits;
	logic [1:0]  status;

	modport source (output valid, chosen_task, switch_needed, ready_bits, status, input ready);
	modport sink (input valid, chosen_task, switch_needed, ready_bits, status, output ready);
endinterface
`default_nettype wire

/* rtl/round_robin_task_scheduler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Round-robin task scheduler core
// Handles tick, register, delay and schedule requests over a row of task
// cells, giving one result word per request word.
// ---------------------------------------------------------------------------
// One request word is handled at a time and always yields one result word.
// A register request, or a failed delay, passes from acceptance through the
// done state back to idle. A tick passes through the tick state, as the tick token
// walks the row of task cells one cell per cycle. A schedule, or a
// successful delay, passes through the search state, as the search
// token walks from the slot after the last chosen one until it reaches a
// ready task, wrapping to slot 1. A finished result waits in an output
// register, so the next request may be accepted before it is taken.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler_core
	import rrts_pkg::*;
#(
	parameter int unsigned MAX_TASKS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrts_req_if.sink   req,
	rrts_res_if.source res
);

	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] total_q;
	logic [SLOT_W-1:0] rot_q;
	logic [SLOT_W-1:0] run_q;
	logic              run_vld_q;

	logic [SLOT_W-1:0] res_chosen_q;
	logic              res_sw_q;
	status_t           res_status_q;

	logic              out_vld_q;
	logic [SLOT_W-1:0] out_chosen_q;
	logic              out_sw_q;
	logic [DATA_W-1:0] out_mask_q;
	status_t           out_status_q;

	rrts_ctl_t         ctl;
	logic              acc;
	req_type_t         rtype;
	logic [SLOT_W-1:0] cur_chosen;
	logic [SLOT_W-1:0] nxt_rot;
	logic              table_full;
	logic              res_ld;
	logic [SLOT_W-1:0] res_chosen_d;
	logic              res_sw_d;
	status_t           res_status_d;
	logic              tot_inc;
	logic              pick_en;
	logic [SLOT_W-1:0] pick_idx;
	logic              out_ld;

	logic [MAX_TASKS:1] tick_in, tick_out, tok_in, tok_out, found_w, ready_w;
	logic               wrap_tok;
	logic               any_found;
	logic [SLOT_W-1:0]  found_idx;
	logic [DATA_W-1:0]  mask_w;

	assign acc        = req.valid && req.ready;
	assign rtype      = req_type_t'(req.req_type);
	assign cur_chosen = run_vld_q ? run_q : '0;
	assign nxt_rot    = rot_q + SLOT_W'(1);
	assign table_full = (total_q >= SLOT_W'(MAX_TASKS + 1));

	always_comb begin
		wrap_tok  = 1'b0;
		any_found = 1'b0;
		found_idx = '0;
		mask_w    = '0;
		for (int k = 1; k <= MAX_TASKS; k++) begin
			if (tok_out[k] && (total_q == SLOT_W'(k + 1))) begin
				wrap_tok = 1'b1;
			end
			if (found_w[k]) begin
				any_found = 1'b1;
				found_idx = found_idx | SLOT_W'(k);
			end
			mask_w[k-1] = ready_w[k];
		end
	end

	for (genvar k = 1; k <= MAX_TASKS; k++) begin : g_cell
		if (k == 1) begin : g_head
			assign tick_in[k] = ctl.tick_go;
			assign tok_in[k]  = wrap_tok;
		end else begin : g_body
			assign tick_in[k] = tick_out[k-1];
			assign tok_in[k]  = tok_out[k-1] && (total_q != SLOT_W'(k));
		end

		rrts_cell #(
			.SLOT(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tick_in (tick_in[k]),
			.tick_out(tick_out[k]),
			.tok_in  (tok_in[k]),
			.tok_out (tok_out[k]),
			.found   (found_w[k]),
			.ready   (ready_w[k])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (rtype)
						REQ_TICK:  state_d = S_TICK;
						REQ_REG:   state_d = S_DONE;
						REQ_DELAY: state_d = (!run_vld_q || run_q == '0) ? S_DONE : S_SEARCH;
						REQ_SCHED: state_d = S_SEARCH;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_TICK: begin
				if (cnt_q == CNT_W'(MAX_TASKS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_SEARCH: begin
				if (res_ld) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || res.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		req.ready    = (state_q == S_IDLE);
		res_ld       = 1'b0;
		res_chosen_d = cur_chosen;
		res_sw_d     = 1'b0;
		res_status_d = STAT_OK;
		tot_inc      = 1'b0;
		pick_en      = 1'b0;
		pick_idx     = '0;
		out_ld       = 1'b0;
		ctl.start    = (nxt_rot >= total_q) ? SLOT_W'(1) : nxt_rot;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					res_ld = 1'b1;
					case (rtype)
						REQ_REG: begin
							if (table_full) begin
								res_status_d = STAT_FULL;
								res_chosen_d = '0;
							end else begin
								res_chosen_d = total_q;
								tot_inc      = 1'b1;
								ctl.wr_en    = (total_q != '0);
								ctl.wr_slot  = total_q;
								ctl.wr_value = '0;
								ctl.wr_ready = 1'b1;
							end
						end
						REQ_DELAY: begin
							if (!run_vld_q || run_q == '0) begin
								res_status_d = STAT_IDLE_DLY;
							end else begin
								ctl.wr_en    = 1'b1;
								ctl.wr_slot  = run_q;
								ctl.wr_value = req.delay_ticks;
								ctl.wr_ready = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_TICK: begin
				ctl.tick_go = (cnt_q == '0);
			end
			S_SEARCH: begin
				if (cnt_q == '0 && total_q == '0) begin
					res_ld = 1'b1;
				end else if (cnt_q == '0 && mask_w == '0) begin
					pick_en = 1'b1;
				end else begin
					ctl.inject = (cnt_q == '0);
					if (any_found) begin
						pick_en  = 1'b1;
						pick_idx = found_idx;
					end else if (cnt_q == CNT_W'(MAX_TASKS)) begin
						pick_en   = 1'b1;
						ctl.flush = 1'b1;
					end
				end
				if (pick_en) begin
					res_ld       = 1'b1;
					res_chosen_d = pick_idx;
					res_sw_d     = !run_vld_q || (run_q != pick_idx);
				end
			end
			S_DONE: begin
				out_ld = !out_vld_q || res.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			total_q   <= '0;
			rot_q     <= '0;
			run_q     <= '0;
			run_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			if (tot_inc) begin
				total_q <= total_q + SLOT_W'(1);
			end
			if (pick_en) begin
				rot_q     <= pick_idx;
				run_q     <= pick_idx;
				run_vld_q <= 1'b1;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_chosen_q <= res_chosen_d;
			res_sw_q     <= res_sw_d;
			res_status_q <= res_status_d;
		end
		if (out_ld) begin
			out_chosen_q <= res_chosen_q;
			out_sw_q     <= res_sw_q;
			out_mask_q   <= mask_w;
			out_status_q <= res_status_q;
		end
	end

	assign res.valid         = out_vld_q;
	assign res.chosen_task   = out_chosen_q;
	assign res.switch_needed = out_sw_q;
	assign res.ready_bits    = out_mask_q;
	assign res.status        = out_status_q;

endmodule
`default_nettype wire

/* rtl/rrts_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Task cell
// Holds the timeout and ready flag of one task slot. A tick token and a
// search token pass through the row of cells, one cell per cycle.
// ---------------------------------------------------------------------------
module rrts_cell
	import rrts_pkg::*;
#(
	parameter int unsigned SLOT = 1
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rrts_ctl_t ctl,
	input  wire logic      tick_in,
	output logic           tick_out,
	input  wire logic      tok_in,
	output logic           tok_out,
	output logic           found,
	output logic           ready
);

	logic [DATA_W-1:0] timeout_q;
	logic              ready_q;
	logic              tick_q;
	logic              tok_q;
	logic              wr_hit;
	logic              tok_eff;

	assign wr_hit   = ctl.wr_en && (ctl.wr_slot == SLOT_W'(SLOT));
	assign tok_eff  = tok_in || (ctl.inject && (ctl.start == SLOT_W'(SLOT)));
	assign found    = tok_eff && ready_q;
	assign ready    = ready_q;
	assign tick_out = tick_q;
	assign tok_out  = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
			ready_q   <= 1'b0;
			tick_q    <= 1'b0;
			tok_q     <= 1'b0;
		end else begin
			tick_q <= tick_in;
			tok_q  <= tok_eff && !ready_q && !ctl.flush;
			if (wr_hit) begin
				timeout_q <= ctl.wr_value;
				ready_q   <= ctl.wr_ready;
			end else if (tick_in && (timeout_q != '0)) begin
				timeout_q <= timeout_q - DATA_W'(1);
				if (timeout_q == DATA_W'(1)) begin
					ready_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Round-robin task scheduler core testbench
// Drives tick, register, delay and schedule request words into the core,
// predicts every result word from a model of the scheduler's own state and
// compares each result field by field, with random idling on both channels
// and one long stall of the result channel.
// ---------------------------------------------------------------------------
module testbench;
	import rrts_pkg::*;

	localparam int unsigned MAX_TASKS = 32;
	localparam int unsigned SLOT_COUNT = MAX_TASKS + 1;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_WORDS = 1230;

	typedef struct packed {
		req_type_t   kind;
		logic [31:0] ticks;
	} kernel_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen;
		logic              switched;
		logic [31:0]       ready;
		status_t           status;
	} sched_decision_t;

	logic clk;
	logic arst_n;

	rrts_req_if req_bus ();
	rrts_res_if res_bus ();

	round_robin_task_scheduler_core #(
		.MAX_TASKS(MAX_TASKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus)
	);

	kernel_req_t     kernel_requests[$];
	sched_decision_t sched_decisions[$];

	logic [31:0]       ready_tasks;
	int unsigned       task_count;
	logic [SLOT_W-1:0] rotate_slot;
	logic [SLOT_W-1:0] running_slot;
	logic              running_flag;
	logic [31:0]       task_timeouts[SLOT_COUNT];

	int unsigned kind_counts[4];
	int unsigned full_refusals;
	int unsigned idle_refusals;
	int unsigned switch_count;
	int unsigned words_accepted;
	int unsigned results_checked;
	int unsigned failures;
	int unsigned cycle_count;
	int unsigned send_gap;
	int unsigned take_stall;
	logic        long_hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_TICK;
		req_bus.delay_ticks = '0;
		res_bus.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("round_robin_task_scheduler_core test failed");
			$finish;
		end
	end

	// When any task is registered, advances the rotation to the next ready task,
	// or to the idle task when nothing is ready, and makes the choice the running task.
	function automatic logic rotate_to_next();
		logic [SLOT_W-1:0] idx;
		logic              found;
		logic              switched;
		idx = rotate_slot;
		found = 1'b0;
		if (task_count == 0)
			return 1'b0;
		if (ready_tasks == '0) begin
			idx = '0;
		end else begin
			for (int step = 0; step < SLOT_COUNT + 1 && !found; step++) begin
				idx++;
				if (idx >= task_count)
					idx = SLOT_W'(1);
				if (idx != 0 && ready_tasks[idx - 1])
					found = 1'b1;
			end
			if (!found)
				idx = '0;
		end
		rotate_slot = idx;
		switched = !running_flag || running_slot != idx;
		running_slot = idx;
		running_flag = 1'b1;
		return switched;
	endfunction

	function automatic sched_decision_t schedule_step(input kernel_req_t rq);
		sched_decision_t d;
		d.chosen = running_flag ? running_slot : '0;
		d.switched = 1'b0;
		d.status = STAT_OK;
		kind_counts[rq.kind]++;
		case (rq.kind)
			REQ_TICK: begin
				for (int n = 1; n < task_count && n < SLOT_COUNT; n++) begin
					if (task_timeouts[n] != 0) begin
						task_timeouts[n]--;
						if (task_timeouts[n] == 0)
							ready_tasks[n - 1] = 1'b1;
					end
				end
			end
			REQ_REG: begin
				if (task_count >= SLOT_COUNT) begin
					d.status = STAT_FULL;
					d.chosen = '0;
				end else begin
					d.chosen = SLOT_W'(task_count);
					task_timeouts[task_count] = '0;
					if (task_count != 0)
						ready_tasks[task_count - 1] = 1'b1;
					task_count++;
				end
			end
			REQ_DELAY: begin
				if (!running_flag || running_slot == 0) begin
					d.status = STAT_IDLE_DLY;
				end else begin
					task_timeouts[running_slot] = rq.ticks;
					ready_tasks[running_slot - 1] = 1'b0;
					d.switched = rotate_to_next();
					d.chosen = running_slot;
				end
			end
			default: begin
				d.switched = rotate_to_next();
				d.chosen = running_flag ? running_slot : '0;
			end
		endcase
		d.ready = ready_tasks;
		if (d.status == STAT_FULL)
			full_refusals++;
		if (d.status == STAT_IDLE_DLY)
			idle_refusals++;
		if (d.switched)
			switch_count++;
		return d;
	endfunction

	// Every third stretch of a hundred words runs with no idling at all.
	function automatic int unsigned pick_idle(input int unsigned seq);
		if ((seq / 100) % 3 == 1)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 15);
		return $urandom_range(3);
	endfunction

	task automatic add_request(input req_type_t kind, input logic [31:0] ticks);
		kernel_req_t rq;
		rq.kind = kind;
		rq.ticks = ticks;
		kernel_requests.push_back(rq);
	endtask

	always @(posedge clk or negedge arst_n) begin
		kernel_req_t rq;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			ready_tasks = '0;
			task_count = 0;
			rotate_slot = '0;
			running_slot = '0;
			running_flag = 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++)
				task_timeouts[i] = '0;
			send_gap = 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				rq.kind = req_type_t'(req_bus.req_type);
				rq.ticks = req_bus.delay_ticks;
				sched_decisions.push_back(schedule_step(rq));
				words_accepted++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req_bus.valid <= 1'b0;
				end else if (kernel_requests.size() != 0) begin
					rq = kernel_requests.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.req_type <= rq.kind;
					req_bus.delay_ticks <= rq.ticks;
					send_gap = pick_idle(words_accepted);
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		sched_decision_t exp_d;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			take_stall = 0;
			long_hold_done = 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				results_checked++;
				if (sched_decisions.size() == 0) begin
					$display("%0t: result word with none expected: chosen_task %0d", $time,
						res_bus.chosen_task);
					failures++;
				end else begin
					exp_d = sched_decisions.pop_front();
					if (res_bus.chosen_task !== exp_d.chosen) begin
						$display("%0t: chosen_task expected %0d, got %0d", $time,
							exp_d.chosen, res_bus.chosen_task);
						failures++;
					end
					if (res_bus.switch_needed !== exp_d.switched) begin
						$display("%0t: switch_needed expected %0b, got %0b", $time,
							exp_d.switched, res_bus.switch_needed);
						failures++;
					end
					if (res_bus.ready_bits !== exp_d.ready) begin
						$display("%0t: ready_bits expected %h, got %h", $time,
							exp_d.ready, res_bus.ready_bits);
						failures++;
					end
					if (res_bus.status !== exp_d.status) begin
						$display("%0t: status expected %0d, got %0d", $time,
							exp_d.status, res_bus.status);
						failures++;
					end
				end
				if (results_checked == 300 && !long_hold_done) begin
					take_stall = 400;
					long_hold_done = 1'b1;
				end
			end
			if (take_stall != 0) begin
				take_stall--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
				if ($urandom_range(2) == 0)
					take_stall = pick_idle(results_checked);
			end
		end
	end

	initial begin
		int unsigned regs_issued;
		int unsigned pick;
		logic [31:0] ticks;

		add_request(REQ_SCHED, $urandom);
		add_request(REQ_DELAY, 32'd5);
		add_request(REQ_TICK, $urandom);
		add_request(REQ_REG, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_DELAY, 32'hffff_ffff);
		add_request(REQ_REG, $urandom);
		add_request(REQ_REG, $urandom);
		add_request(REQ_REG, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_DELAY, 32'hffff_ffff);
		add_request(REQ_DELAY, 32'd2);
		add_request(REQ_DELAY, 32'd0);
		add_request(REQ_TICK, $urandom);
		add_request(REQ_TICK, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_SCHED, $urandom);
		add_request(REQ_DELAY, 32'd1);
		add_request(REQ_TICK, $urandom);
		add_request(REQ_SCHED, $urandom);
		regs_issued = 4;

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 900 && regs_issued < SLOT_COUNT + 3) begin
				while (regs_issued < SLOT_COUNT + 3) begin
					add_request(REQ_REG, $urandom);
					regs_issued++;
				end
			end
			pick = $urandom_range(99);
			if (pick < 4) begin
				add_request(REQ_REG, $urandom);
				regs_issued++;
			end else if (pick < 34) begin
				add_request(REQ_TICK, $urandom);
			end else if (pick < 64) begin
				case ($urandom_range(19))
					0: ticks = '0;
					1: ticks = $urandom;
					default: ticks = $urandom_range(6, 1);
				endcase
				add_request(REQ_DELAY, ticks);
			end else begin
				add_request(REQ_SCHED, $urandom);
			end
		end

		wait (arst_n === 1'b1);
		while (kernel_requests.size() != 0 || req_bus.valid || sched_decisions.size() != 0)
			@(negedge clk);
		repeat (2 * MAX_TASKS + 8) @(posedge clk);

		$display("Checked %0d result words: %0d ticks, %0d registrations, %0d delays, %0d schedules.",
			results_checked, kind_counts[REQ_TICK], kind_counts[REQ_REG],
			kind_counts[REQ_DELAY], kind_counts[REQ_SCHED]);
		$display("Saw %0d table-full refusals, %0d idle-task delays and %0d context switches.",
			full_refusals, idle_refusals, switch_count);
		if (failures == 0)
			$display("round_robin_task_scheduler_core test passed");
		else
			$display("round_robin_task_scheduler_core test failed");
		$finish;
	end

endmodule
